/* hw/rtl/sv39m_pkg.sv */
package sv39m_pkg;

    localparam int VA_W    = 39;
    localparam int PA_W    = 56;
    localparam int PPN_W   = 44;
    localparam int PTE_W   = 54;
    localparam int PERM_W  = 10;
    localparam int OFF_W   = 12;
    localparam int VPN_W   = 9;
    localparam int LEVEL_W = 2;

    localparam logic [LEVEL_W-1:0] LVL_ROOT = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_MID  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_LEAF = 2'd0;

    localparam logic [PPN_W-1:0] POOL_BASE_RESET = 44'd524288;

    typedef enum logic [0:0] {
        OP_MAP       = 1'b0,
        OP_TRANSLATE = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_UNALIGNED_V = 3'd1,
        ST_UNALIGNED_P = 3'd2,
        ST_REMAP       = 3'd3,
        ST_NOPERM      = 3'd4,
        ST_FULL        = 3'd5,
        ST_FAULT       = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        opcode_t           opcode;
        logic [VA_W-1:0]   virt_addr;
        logic [PA_W-1:0]   target_pa;
        logic [PERM_W-1:0] perm_bits;
    } req_t;

    typedef struct packed {
        status_t         status;
        logic [PA_W-1:0] result_addr;
    } rsp_t;

    typedef struct packed {
        logic          clr_wr;
        logic          accept;
        logic          step_ptr;
        logic          alloc;
        logic          write_leaf;
        logic          set_res;
        status_t       res_code;
        logic          res_addr_sel;
        logic          load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_map;
        logic va_unaligned;
        logic pa_unaligned;
        logic level_zero;
        logic entry_v;
        logic ptr_ok;
        logic pool_full;
        logic no_perm;
        logic clr_last;
        logic out_free;
    } dp_status_t;

endpackage

/* hw/rtl/sv39m_stream_if.sv */
interface sv39m_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/sv39m_ram.sv */
module sv39m_ram #(
    parameter int WIDTH = 54,
    parameter int DEPTH = 32768,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/sv39m_ctrl.sv */
module sv39m_ctrl
    import sv39m_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        cmd.res_code = ST_OK;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // read is issued every cycle; alignment only matters for map
                if (st.is_map && st.va_unaligned)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_UNALIGNED_V;
                    state_next   = S_DONE;
                end
                else if (st.is_map && st.pa_unaligned)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_UNALIGNED_P;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_DONE;
                if (!st.level_zero)
                begin
                    if (st.entry_v)
                    begin
                        if (st.ptr_ok)
                        begin
                            cmd.step_ptr = 1'b1;
                            state_next   = S_READ;
                        end
                        else
                        begin
                            cmd.set_res  = 1'b1;
                            cmd.res_code = ST_FAULT;
                        end
                    end
                    else if (st.is_map)
                    begin
                        if (st.pool_full)
                        begin
                            cmd.set_res  = 1'b1;
                            cmd.res_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.alloc  = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = ST_FAULT;
                    end
                end
                else if (st.is_map)
                begin
                    cmd.set_res = 1'b1;
                    if (st.entry_v)
                    begin
                        cmd.res_code = ST_REMAP;
                    end
                    else if (st.no_perm)
                    begin
                        cmd.res_code = ST_NOPERM;
                    end
                    else
                    begin
                        cmd.write_leaf = 1'b1;
                        cmd.res_code   = ST_OK;
                    end
                end
                else
                begin
                    cmd.set_res = 1'b1;
                    if (st.entry_v)
                    begin
                        cmd.res_code     = ST_OK;
                        cmd.res_addr_sel = 1'b1;
                    end
                    else
                    begin
                        cmd.res_code = ST_FAULT;
                    end
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

/* hw/rtl/sv39m_dp.sv */
module sv39m_dp
    import sv39m_pkg::*;
#(
    parameter int POOL_PAGES = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       st,
    input  req_t             req_data,
    input  logic             cfg_wr,
    input  logic [PPN_W-1:0] cfg_data,
    input  logic             rsp_ready,
    output logic             rsp_valid,
    output rsp_t             rsp_data
);

    localparam int DEPTH = POOL_PAGES * (1 << VPN_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(POOL_PAGES);
    localparam int NW    = $clog2(POOL_PAGES + 1);

    // item payload
    opcode_t           op_reg;
    logic [VA_W-1:0]   va_reg;
    logic [PA_W-1:0]   pa_reg;
    logic [PERM_W-1:0] perm_reg;

    // walk state
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [PW-1:0]      page_reg, page_next;
    logic [NW-1:0]      nfp_reg, nfp_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [PPN_W-1:0]   base_reg, base_next;

    // result staging and output
    status_t         res_status_reg;
    logic [PA_W-1:0] res_addr_reg;
    logic            out_valid_reg, out_valid_next;
    rsp_t            out_data_reg;

    logic [VPN_W-1:0] vpn;
    logic [AW-1:0]    walk_addr;
    logic [PTE_W-1:0] rd_q;
    logic [PPN_W-1:0] ptr_idx;
    logic [PTE_W-1:0] ptr_pte;
    logic [PTE_W-1:0] leaf_pte;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [PTE_W-1:0] ram_wdata;

    always_comb
    begin
        case (level_reg)
            LVL_ROOT: vpn = va_reg[OFF_W+2*VPN_W +: VPN_W];
            LVL_MID:  vpn = va_reg[OFF_W+VPN_W +: VPN_W];
            default:  vpn = va_reg[OFF_W +: VPN_W];
        endcase
    end

    assign walk_addr = {page_reg, vpn};
    assign ptr_idx   = rd_q[PTE_W-1:PERM_W] - base_reg;
    assign ptr_pte   = {base_reg + PPN_W'(nfp_reg), {(PERM_W-1){1'b0}}, 1'b1};
    assign leaf_pte  = {pa_reg[PA_W-1:OFF_W], perm_reg | PERM_W'(1)};

    assign ram_we    = cmd.clr_wr | cmd.alloc | cmd.write_leaf;
    assign ram_waddr = cmd.clr_wr ? clr_addr_reg : walk_addr;
    assign ram_wdata = cmd.clr_wr ? '0 : (cmd.alloc ? ptr_pte : leaf_pte);

    sv39m_ram #(
        .WIDTH (PTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (walk_addr),
        .rdata (rd_q)
    );

    always_comb
    begin
        st.is_map       = (op_reg == OP_MAP);
        st.va_unaligned = (va_reg[OFF_W-1:0] != '0);
        st.pa_unaligned = (pa_reg[OFF_W-1:0] != '0);
        st.level_zero   = (level_reg == LVL_LEAF);
        st.entry_v      = rd_q[0];
        st.ptr_ok       = (ptr_idx < PPN_W'(POOL_PAGES));
        st.pool_full    = (nfp_reg == NW'(POOL_PAGES));
        st.no_perm      = (perm_reg[3:1] == 3'b000);
        st.clr_last     = (clr_addr_reg == AW'(DEPTH - 1));
        st.out_free     = !out_valid_reg || rsp_ready;
    end

    always_comb
    begin
        level_next     = level_reg;
        page_next      = page_reg;
        nfp_next       = nfp_reg;
        clr_addr_next  = clr_addr_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg;
        if (cmd.accept)
        begin
            level_next = LVL_ROOT;
            page_next  = '0;
        end
        if (cmd.step_ptr)
        begin
            level_next = level_reg - LEVEL_W'(1);
            page_next  = ptr_idx[PW-1:0];
        end
        if (cmd.alloc)
        begin
            level_next = level_reg - LEVEL_W'(1);
            page_next  = nfp_reg[PW-1:0];
            nfp_next   = nfp_reg + NW'(1);
        end
        if (cmd.clr_wr)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
        end
        if (cfg_wr)
        begin
            base_next = cfg_data;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= LVL_ROOT;
            page_reg      <= '0;
            nfp_reg       <= NW'(1);
            clr_addr_reg  <= '0;
            base_reg      <= POOL_BASE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            page_reg      <= page_next;
            nfp_reg       <= nfp_next;
            clr_addr_reg  <= clr_addr_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= req_data.opcode;
            va_reg   <= req_data.virt_addr;
            pa_reg   <= req_data.target_pa;
            perm_reg <= req_data.perm_bits;
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_code;
            res_addr_reg   <= cmd.res_addr_sel
                              ? {rd_q[PTE_W-1:PERM_W], va_reg[OFF_W-1:0]} : '0;
        end
        if (cmd.load_out)
        begin
            out_data_reg.status      <= res_status_reg;
            out_data_reg.result_addr <= res_addr_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_nfp_range: assert property (@(posedge clk) disable iff (!rst_n)
        nfp_reg != '0 && nfp_reg <= NW'(POOL_PAGES))
        else $error("free page counter out of range");

    a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> !st.pool_full && !st.level_zero && !st.entry_v)
        else $error("allocation without room or over a valid pointer");

    a_alloc_bump: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |=> nfp_reg == $past(nfp_reg) + NW'(1))
        else $error("free page counter did not advance");

    a_leaf_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_leaf |-> st.level_zero && !st.entry_v && !st.no_perm && st.is_map)
        else $error("leaf written outside a clean map at level 0");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> st.out_free)
        else $error("output register overwritten while held");
`endif

endmodule

/* hw/rtl/sv39_page_table_map_translate.sv */
// Sv39 page table engine over a private pool of POOL_PAGES table pages
// (512 entries each, pool page 0 is the root).
// Channels:
//   req  - sink; one beat is a map (opcode 0) or translate (opcode 1) item.
//   rsp  - source; one beat per request: status and result_addr.
//   cfg  - sink; a beat writes pool_base_ppn. Always ready; write only idle.
// Walk: after accept, rsp becomes valid once the walk is through: a read/decide
//   pair (S_READ, S_WAIT) per table level through the single-port-read
//   store with registered output, then the result state S_DONE.
//   Unaligned map requests finish after the first read slot.
// Throughput: one item at a time; the next request is accepted only after
//   the walk of the last one, with its up to three dependent store reads, is done.
// Reset: the store is swept to zero, one entry per cycle, over all
//   POOL_PAGES*512 entries (32768 at the default); req is not ready during
//   the sweep. The free page counter restarts at 1.
// Stall: a finished result waits in the rsp register; the next request is
//   accepted meanwhile and holds in its result cycle until rsp drains.
module sv39_page_table_map_translate
    import sv39m_pkg::*;
#(
    parameter int POOL_PAGES = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    sv39m_stream_if.sink   req,
    sv39m_stream_if.source rsp,
    sv39m_stream_if.sink   cfg
);

    ctrl_cmd_t  cmd;
    dp_status_t st;
    logic       req_ready;

    // configuration is taken in any cycle
    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

    sv39m_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // store, walk registers, free page counter and result registers
    sv39m_dp #(
        .POOL_PAGES (POOL_PAGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .req_data  (req.data),
        .cfg_wr    (cfg.valid),
        .cfg_data  (cfg.data),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_data  (rsp.data)
    );

endmodule

/* tb/sv39_page_table_map_translate_checker.sv */
module sv39_page_table_map_translate_checker
    import sv39m_pkg::*;
#(
    parameter int POOL_PAGES = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_ready,
    input  req_t             req_data,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  rsp_t             rsp_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [PPN_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    localparam int TABLE_ENTRIES = 512;
    localparam int STORE_DEPTH   = POOL_PAGES * TABLE_ENTRIES;
    localparam int MAX_REPORTS   = 10;
    localparam logic [PERM_W-1:0] PTE_V = 10'h001;

    // shadow copy of the page table pool and the allocator
    logic [PTE_W-1:0] pte_mem [STORE_DEPTH];
    int               next_page;
    logic [PPN_W-1:0] base_ppn;
    rsp_t             rsp_due [$];
    int               fails;

    function automatic int slot_index(input int page, input logic [VA_W-1:0] va,
                                      input int lvl);
        return page * TABLE_ENTRIES + int'(va[OFF_W + VPN_W * lvl +: VPN_W]);
    endfunction

    // pool page named by a pointer entry, -1 when it lies outside the pool
    function automatic int pointer_page(input logic [PTE_W-1:0] pte);
        logic [PPN_W-1:0] idx;
        idx = pte[PTE_W-1:PERM_W] - base_ppn;
        return (idx < POOL_PAGES) ? int'(idx) : -1;
    endfunction

    function automatic status_t map_page(input req_t r);
        int page;
        int lvl;
        int s;
        page = 0;
        if (r.virt_addr[OFF_W-1:0] != '0)
            return ST_UNALIGNED_V;
        if (r.target_pa[OFF_W-1:0] != '0)
            return ST_UNALIGNED_P;
        // links made here stay even when a later check fails
        for (lvl = 2; lvl > 0; lvl--)
        begin
            s = slot_index(page, r.virt_addr, lvl);
            if (pte_mem[s][0])
            begin
                page = pointer_page(pte_mem[s]);
                if (page < 0)
                    return ST_FAULT;
            end
            else
            begin
                if (next_page >= POOL_PAGES)
                    return ST_FULL;
                page = next_page;
                next_page++;
                pte_mem[s] = {base_ppn + PPN_W'(page), PTE_V};
            end
        end
        s = slot_index(page, r.virt_addr, 0);
        if (pte_mem[s][0])
            return ST_REMAP;
        if (r.perm_bits[3:1] == '0)
            return ST_NOPERM;
        pte_mem[s] = {r.target_pa[PA_W-1:OFF_W], r.perm_bits | PTE_V};
        return ST_OK;
    endfunction

    function automatic rsp_t translate_va(input logic [VA_W-1:0] va);
        rsp_t             res;
        int               page;
        int               lvl;
        logic [PTE_W-1:0] pte;
        res.status      = ST_FAULT;
        res.result_addr = '0;
        page            = 0;
        for (lvl = 2; lvl > 0; lvl--)
        begin
            pte = pte_mem[slot_index(page, va, lvl)];
            if (!pte[0])
                return res;
            page = pointer_page(pte);
            if (page < 0)
                return res;
        end
        pte = pte_mem[slot_index(page, va, 0)];
        if (!pte[0])
            return res;
        res.status      = ST_OK;
        res.result_addr = {pte[PTE_W-1:PERM_W], va[OFF_W-1:0]};
        return res;
    endfunction

    function automatic rsp_t walk_result(input req_t r);
        rsp_t res;
        if (r.opcode == OP_MAP)
        begin
            res.status      = map_page(r);
            res.result_addr = '0;
        end
        else
            res = translate_va(r.virt_addr);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        int   i;
        if (!rst_n)
        begin
            for (i = 0; i < STORE_DEPTH; i++)
                pte_mem[i] = '0;
            next_page = 1;
            base_ppn  = POOL_BASE_RESET;
            rsp_due.delete();
            fails      = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                base_ppn = cfg_data;
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    if (fails < MAX_REPORTS)
                        $display("rsp beat with nothing outstanding: status %0d addr %h",
                                 rsp_data.status, rsp_data.result_addr);
                    fails++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp_data.status !== want.status ||
                        rsp_data.result_addr !== want.result_addr)
                    begin
                        if (fails < MAX_REPORTS)
                            $display("rsp mismatch: status %0d addr %h, expected %0d addr %h",
                                     rsp_data.status, rsp_data.result_addr,
                                     want.status, want.result_addr);
                        fails++;
                    end
                end
            end
            if (req_valid && req_ready)
                rsp_due.push_back(walk_result(req_data));
            fail_count <= fails;
            pending    <= rsp_due.size();
        end
    end

endmodule

/* tb/sv39_page_table_map_translate_tb.sv */
module sv39_page_table_map_translate_tb;
    import sv39m_pkg::*;

    typedef logic [PPN_W-1:0] ppn_t;

    localparam int POOL_PAGES      = 64;
    // longest beat-free stretch: the reset sweep over POOL_PAGES*512 entries, times four
    localparam int QUIET_LIMIT     = 131072;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 239;
    localparam int TAIL_CYCLES     = 16;

    localparam logic [PERM_W-1:0] FLAG_R   = 10'h002;
    localparam logic [PERM_W-1:0] FLAG_W   = 10'h004;
    localparam logic [PERM_W-1:0] FLAG_X   = 10'h008;
    localparam logic [PERM_W-1:0] FLAG_RWX = 10'h00E;

    localparam logic [VA_W-1:0] VA_TOP_PAGE = 39'h7F_FFFF_F000;
    localparam logic [PA_W-1:0] PA_TOP_PAGE = 56'hFF_FFFF_FFFF_F000;
    localparam ppn_t            PPN_MAX     = 44'hFFF_FFFF_FFFF;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sv39m_stream_if #(.payload_t(req_t)) req_if ();
    sv39m_stream_if #(.payload_t(rsp_t)) rsp_if ();
    sv39m_stream_if #(.payload_t(ppn_t)) cfg_if ();

    // idle knobs, set per phase by the stimulus thread
    int send_gap_pct = 0;
    int stall_pct    = 0;

    int fail_count;
    int pending;
    int quiet_cycles = 0;

    // address pools that keep the random walks inside tables that already exist
    logic [VPN_W-1:0] l2_set [$];
    logic [VPN_W-1:0] l1_set [3];
    logic [VA_W-1:0]  mapped_va [$];

    // pool base used per phase: phase 0 keeps the reset value; max -> 0 -> 1
    // shifts the pool by one page each time so old links still resolve, the
    // random one leaves older links outside the pool; the last phase is 0 again
    ppn_t base_plan [PHASES];

    sv39_page_table_map_translate #(
        .POOL_PAGES(POOL_PAGES)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if),
        .cfg  (cfg_if)
    );

    sv39_page_table_map_translate_checker #(
        .POOL_PAGES(POOL_PAGES)
    ) u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_if.valid),
        .req_ready (req_if.ready),
        .req_data  (req_if.data),
        .rsp_valid (rsp_if.valid),
        .rsp_ready (rsp_if.ready),
        .rsp_data  (rsp_if.data),
        .cfg_valid (cfg_if.valid),
        .cfg_ready (cfg_if.ready),
        .cfg_data  (cfg_if.data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always #1 clk = ~clk;

    // response side back-pressure
    always @(posedge clk)
        rsp_if.ready <= rst_n && ($urandom_range(99) >= stall_pct);

    // watchdog: any beat on any channel restarts the count
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("sv39_page_table_map_translate test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic req_t map_req(input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa,
                                     input logic [PERM_W-1:0] perm);
        req_t r;
        r.opcode    = OP_MAP;
        r.virt_addr = va;
        r.target_pa = pa;
        r.perm_bits = perm;
        return r;
    endfunction

    // translate ignores target_pa and perm_bits, so fill them with noise
    function automatic req_t translate_req(input logic [VA_W-1:0] va);
        req_t r;
        r.opcode    = OP_TRANSLATE;
        r.virt_addr = va;
        r.target_pa = PA_W'(rand64());
        r.perm_bits = PERM_W'($urandom());
        return r;
    endfunction

    // page aligned address inside the current working set of tables
    function automatic logic [VA_W-1:0] working_va();
        return {l2_set[$urandom_range(l2_set.size() - 1)], l1_set[$urandom_range(2)],
                VPN_W'($urandom_range(511)), OFF_W'(0)};
    endfunction

    // one request beat; waits out the sender gap first, leaves valid high
    task automatic push_req(input req_t item);
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    // stop sending and wait for every outstanding response beat
    task automatic drain();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_pool_base(input ppn_t value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_random();
        req_t             item;
        int               pick;
        logic [VA_W-1:0]  va;
        logic [PA_W-1:0]  pa;
        logic [PERM_W-1:0] perm;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            // map: mostly well formed into the working set, a few stray
            // addresses that eat pool pages until the pool runs dry
            va   = ($urandom_range(99) < 3) ? VA_W'(rand64()) : working_va();
            va[OFF_W-1:0] = '0;
            pa   = PA_W'(rand64());
            pa[OFF_W-1:0] = '0;
            perm = PERM_W'($urandom());
            if (perm[3:1] == '0)
                perm[$urandom_range(3, 1)] = 1'b1;
            if (pick < 40)
                mapped_va.push_back(va);
            else
            begin
                // malformed maps: one defect each, or all fields random
                case (pick % 4)
                    0: va[OFF_W-1:0] = OFF_W'($urandom_range(4095, 1));
                    1: pa[OFF_W-1:0] = OFF_W'($urandom_range(4095, 1));
                    2: perm = perm & ~FLAG_RWX;
                    default:
                    begin
                        va   = VA_W'(rand64());
                        pa   = PA_W'(rand64());
                        perm = PERM_W'($urandom());
                    end
                endcase
            end
            item = map_req(va, pa, perm);
        end
        else
        begin
            // translate: hit earlier maps, probe empty leaves, or wander
            if (pick < 80 && mapped_va.size() != 0)
                va = mapped_va[$urandom_range(mapped_va.size() - 1)];
            else if (pick < 92)
                va = working_va();
            else
                va = VA_W'(rand64());
            va[OFF_W-1:0] = OFF_W'($urandom_range(4095));
            item = translate_req(va);
        end
        push_req(item);
    endtask

    task automatic run_directed();
        push_req(translate_req('0));                                  // empty root
        push_req(map_req(39'h7F_FFFF_FFFF, '1, '1));                  // virt checked first
        push_req(map_req(VA_TOP_PAGE, '1, '1));                       // unaligned phys
        push_req(map_req(VA_TOP_PAGE, PA_TOP_PAGE, '1));              // top page, all flags
        push_req(translate_req(39'h7F_FFFF_FFFF));                    // all-ones address
        push_req(map_req(VA_TOP_PAGE, '0, FLAG_R));                   // remap
        push_req(map_req('0, '0, '0));                                // no R/W/X, links kept
        push_req(map_req('0, '0, 10'h3F1));                           // other flags only
        push_req(map_req('0, '0, FLAG_R));
        push_req(translate_req('0));                                  // ok with address 0
        push_req(map_req(39'h1000, 56'h1000, FLAG_W));
        push_req(map_req(39'h2000, PA_TOP_PAGE, FLAG_X));
        push_req(translate_req(39'h1FFF));
        push_req(translate_req(39'h2ABC));
        push_req(translate_req(39'h3000));                            // leaf missing
        push_req(translate_req(39'h4000_0000));                       // root entry missing
        push_req(translate_req(39'h20_0000));                         // mid entry missing
        mapped_va.push_back(39'h1000);
        mapped_va.push_back(39'h2000);
        mapped_va.push_back(VA_TOP_PAGE);
    endtask

    initial
    begin
        int ph;
        int k;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;

        base_plan[0] = POOL_BASE_RESET;
        base_plan[1] = PPN_MAX;
        base_plan[2] = '0;
        base_plan[3] = 44'd1;
        base_plan[4] = ppn_t'(rand64());
        base_plan[5] = '0;
        for (k = 0; k < 3; k++)
            l1_set[k] = VPN_W'($urandom_range(511));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // the first beat waits out the store sweep through the handshake
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph != 0)
            begin
                drain();
                write_pool_base(base_plan[ph]);
            end
            case (ph % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 45; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 45; end
                default: begin send_gap_pct = 27; stall_pct = 27; end
            endcase
            // two fresh root slots per phase; older ones stay in play
            l2_set.push_back(VPN_W'($urandom_range(511)));
            l2_set.push_back(VPN_W'($urandom_range(511)));
            if (ph == 0)
                run_directed();
            repeat (ITEMS_PER_PHASE) send_random();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("sv39_page_table_map_translate test passed");
        else
            $display("sv39_page_table_map_translate test failed");
        $finish;
    end

endmodule
